/* rtl/rna_pkg.sv */
// Shared types and constants for the radius neighbour averaging block.
package rna_pkg;

  localparam int POS_W    = 20;
  localparam int VEL_W    = 16;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 6;
  localparam int RAD_W    = 20;
  localparam int AIU_W    = 7;
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int R2_W     = 2 * RAD_W;
  localparam int PSUM_W   = POS_W + CNT_W;
  localparam int VSUM_W   = VEL_W + CNT_W;
  localparam int STEP_W   = $clog2(PSUM_W);
  localparam int NUM_MEANS = 4;
  localparam int SEL_W    = $clog2(NUM_MEANS);

  localparam logic [CNT_W-1:0] COUNT_CAP     = 6'd63;
  localparam logic [RAD_W-1:0] RADIUS_RESET  = 20'd160;
  localparam logic [AIU_W-1:0] AGENTS_RESET  = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_AGENTS = 1'b1;

  localparam logic [SEL_W-1:0] SEL_POS_X = 2'd0;
  localparam logic [SEL_W-1:0] SEL_POS_Y = 2'd1;
  localparam logic [SEL_W-1:0] SEL_VEL_X = 2'd2;
  localparam logic [SEL_W-1:0] SEL_VEL_Y = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

endpackage

/* rtl/radius_neighbor_average.sv */
// Top level: agent table memories, neighbour walk pipeline and shared divider.
// Write transaction: stored in the agent table, no result.
// Query: one table read per walk cycle, then, if any neighbour was found, the
// bit-serial divider computes each of the four means in turn.
// One query in flight; the next transaction is taken once the result sits in the output reg.
// Reset clears control, pipeline valids, accumulators and registers (radius 160, 64 agents);
// table contents stay undefined until written.
module radius_neighbor_average #(
  parameter int MAX_AGENTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic [rna_pkg::IDX_W-1:0]        agent_index,
  input  logic signed [rna_pkg::POS_W-1:0] position_x,
  input  logic signed [rna_pkg::POS_W-1:0] position_y,
  input  logic signed [rna_pkg::VEL_W-1:0] velocity_x,
  input  logic signed [rna_pkg::VEL_W-1:0] velocity_y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rna_pkg::CNT_W-1:0]        neighbor_count,
  output logic signed [rna_pkg::POS_W-1:0] mean_position_x,
  output logic signed [rna_pkg::POS_W-1:0] mean_position_y,
  output logic signed [rna_pkg::VEL_W-1:0] mean_velocity_x,
  output logic signed [rna_pkg::VEL_W-1:0] mean_velocity_y,
  output logic                             no_neighbors,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [rna_pkg::RAD_W-1:0]        cfg_data
);

  localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int WW = $clog2(MAX_AGENTS + 1);

  localparam int POS_W  = rna_pkg::POS_W;
  localparam int VEL_W  = rna_pkg::VEL_W;
  localparam int CNT_W  = rna_pkg::CNT_W;
  localparam int DIFF_W = rna_pkg::DIFF_W;
  localparam int SQ_W   = rna_pkg::SQ_W;
  localparam int R2_W   = rna_pkg::R2_W;
  localparam int PSUM_W = rna_pkg::PSUM_W;
  localparam int VSUM_W = rna_pkg::VSUM_W;
  localparam int STEP_W = rna_pkg::STEP_W;
  localparam int SEL_W  = rna_pkg::SEL_W;

  // Configuration
  logic [rna_pkg::RAD_W-1:0] radius;
  logic [rna_pkg::AIU_W-1:0] agents_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= rna_pkg::RADIUS_RESET;
      agents_in_use <= rna_pkg::AGENTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rna_pkg::CFG_RADIUS: radius <= cfg_data;
        rna_pkg::CFG_AGENTS: agents_in_use <= cfg_data[rna_pkg::AIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Control
  rna_pkg::state_t state, state_next;
  logic            issue;
  logic            load_out;
  logic            in_accept;
  logic            in_range;
  logic            pipe_busy;

  logic [WW-1:0]    walk_cnt;
  logic [WW-1:0]    walk_len;
  logic [STEP_W-1:0] div_step;
  logic [SEL_W-1:0] div_sel;
  logic [CNT_W-1:0] found_count;

  logic p1_v, p2_v, p3_v;

  assign in_accept = in_valid && !in_stall;
  assign in_range  = 32'(agent_index) < 32'(MAX_AGENTS);
  assign pipe_busy = p1_v || p2_v || p3_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rna_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    load_out   = 1'b0;
    in_stall   = 1'b1;
    case (state)
      rna_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && operation == rna_pkg::OP_QUERY) begin
          state_next = rna_pkg::ST_CENTER;
        end
      end
      rna_pkg::ST_CENTER: begin
        state_next = rna_pkg::ST_WALK;
      end
      rna_pkg::ST_WALK: begin
        if (walk_cnt == walk_len) begin
          state_next = rna_pkg::ST_DRAIN;
        end else begin
          issue = 1'b1;
        end
      end
      rna_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = (found_count == '0) ? rna_pkg::ST_FINISH : rna_pkg::ST_DIV_LOAD;
        end
      end
      rna_pkg::ST_DIV_LOAD: begin
        state_next = rna_pkg::ST_DIV_RUN;
      end
      rna_pkg::ST_DIV_RUN: begin
        if (div_step == STEP_W'(PSUM_W - 1)) begin
          state_next = (div_sel == rna_pkg::SEL_VEL_Y) ? rna_pkg::ST_FINISH
                                                       : rna_pkg::ST_DIV_LOAD;
        end
      end
      rna_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = rna_pkg::ST_IDLE;
        end
      end
      default: state_next = rna_pkg::ST_IDLE;
    endcase
  end

  // Agent table
  logic [2*POS_W-1:0] pos_mem [MAX_AGENTS];
  logic [2*VEL_W-1:0] vel_mem [MAX_AGENTS];
  logic [2*POS_W-1:0] pos_rd;
  logic [2*VEL_W-1:0] vel_rd;
  logic [AW-1:0]      rd_addr;

  assign rd_addr = (state == rna_pkg::ST_IDLE) ? AW'(agent_index) : walk_cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_accept && operation == rna_pkg::OP_WRITE && in_range) begin
      pos_mem[AW'(agent_index)] <= {position_y, position_x};
      vel_mem[AW'(agent_index)] <= {velocity_y, velocity_x};
    end
    pos_rd <= pos_mem[rd_addr];
    vel_rd <= vel_mem[rd_addr];
  end

  // Query set-up
  logic [rna_pkg::IDX_W-1:0] q_idx;
  logic                      q_in_range;
  logic signed [POS_W-1:0]   cx, cy;
  logic [R2_W-1:0]           r2;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_idx      <= agent_index;
      q_in_range <= in_range;
    end
    if (state == rna_pkg::ST_CENTER) begin
      cx       <= q_in_range ? pos_rd[POS_W-1:0] : '0;
      cy       <= q_in_range ? pos_rd[2*POS_W-1:POS_W] : '0;
      r2       <= R2_W'(radius) * R2_W'(radius);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_cnt <= '0;
      walk_len <= '0;
    end else if (state == rna_pkg::ST_CENTER) begin
      walk_cnt <= '0;
      walk_len <= (32'(agents_in_use) > 32'(MAX_AGENTS)) ? WW'(MAX_AGENTS)
                                                         : WW'(agents_in_use);
    end else if (issue) begin
      walk_cnt <= walk_cnt + 1'b1;
    end
  end

  // Walk pipeline: read, distance, square, accumulate
  logic [AW-1:0]            p1_tag;
  logic signed [POS_W-1:0]  rd_px, rd_py;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        ax, ay;

  logic [DIFF_W-1:0]        p2_ax, p2_ay;
  logic                     p2_excl, p3_excl;
  logic signed [POS_W-1:0]  p2_px, p2_py, p3_px, p3_py;
  logic signed [VEL_W-1:0]  p2_vx, p2_vy, p3_vx, p3_vy;
  logic [SQ_W-1:0]          p3_sqx, p3_sqy;
  logic [SQ_W-1:0]          d2;
  logic                     hit;

  assign rd_px = pos_rd[POS_W-1:0];
  assign rd_py = pos_rd[2*POS_W-1:POS_W];
  assign dx    = DIFF_W'(rd_px) - DIFF_W'(cx);
  assign dy    = DIFF_W'(rd_py) - DIFF_W'(cy);
  assign ax    = dx[DIFF_W-1] ? -dx : dx;
  assign ay    = dy[DIFF_W-1] ? -dy : dy;
  assign d2    = p3_sqx + p3_sqy;
  assign hit   = p3_v && !p3_excl && (d2 < SQ_W'(r2)) && (found_count != rna_pkg::COUNT_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      p1_v <= issue;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_tag  <= walk_cnt[AW-1:0];
    p2_ax   <= ax;
    p2_ay   <= ay;
    p2_excl <= 32'(p1_tag) == 32'(q_idx);
    p2_px   <= rd_px;
    p2_py   <= rd_py;
    p2_vx   <= vel_rd[VEL_W-1:0];
    p2_vy   <= vel_rd[2*VEL_W-1:VEL_W];
    p3_sqx  <= SQ_W'(p2_ax) * SQ_W'(p2_ax);
    p3_sqy  <= SQ_W'(p2_ay) * SQ_W'(p2_ay);
    p3_excl <= p2_excl;
    p3_px   <= p2_px;
    p3_py   <= p2_py;
    p3_vx   <= p2_vx;
    p3_vy   <= p2_vy;
  end

  logic signed [PSUM_W-1:0] pos_sum_x, pos_sum_y;
  logic signed [VSUM_W-1:0] vel_sum_x, vel_sum_y;

  always_ff @(posedge clk) begin
    if (rst || state == rna_pkg::ST_CENTER) begin
      pos_sum_x   <= '0;
      pos_sum_y   <= '0;
      vel_sum_x   <= '0;
      vel_sum_y   <= '0;
      found_count <= '0;
    end else if (hit) begin
      pos_sum_x   <= pos_sum_x + PSUM_W'(p3_px);
      pos_sum_y   <= pos_sum_y + PSUM_W'(p3_py);
      vel_sum_x   <= vel_sum_x + VSUM_W'(p3_vx);
      vel_sum_y   <= vel_sum_y + VSUM_W'(p3_vy);
      found_count <= found_count + 1'b1;
    end
  end

  // Shared restoring divider, one quotient bit a cycle, sign handled on magnitudes
  logic signed [PSUM_W-1:0] dividend;
  logic [PSUM_W-1:0]        div_quo, quo_next;
  logic [CNT_W-1:0]         div_rem, rem_next;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic                     div_neg;
  logic signed [PSUM_W-1:0] means [rna_pkg::NUM_MEANS];

  always_comb begin
    case (div_sel)
      rna_pkg::SEL_POS_X: dividend = pos_sum_x;
      rna_pkg::SEL_POS_Y: dividend = pos_sum_y;
      rna_pkg::SEL_VEL_X: dividend = PSUM_W'(vel_sum_x);
      rna_pkg::SEL_VEL_Y: dividend = PSUM_W'(vel_sum_y);
      default:            dividend = '0;
    endcase
    trial    = {div_rem, div_quo[PSUM_W-1]};
    trial_ge = trial >= {1'b0, found_count};
    rem_next = trial_ge ? CNT_W'(trial - {1'b0, found_count}) : trial[CNT_W-1:0];
    quo_next = {div_quo[PSUM_W-2:0], trial_ge};
  end

  always_ff @(posedge clk) begin
    if (rst || state == rna_pkg::ST_CENTER) begin
      div_sel <= '0;
    end else if (state == rna_pkg::ST_DIV_RUN && div_step == STEP_W'(PSUM_W - 1)) begin
      div_sel <= div_sel + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rna_pkg::ST_DIV_LOAD: begin
        div_neg  <= dividend[PSUM_W-1];
        div_quo  <= dividend[PSUM_W-1] ? -dividend : dividend;
        div_rem  <= '0;
        div_step <= '0;
      end
      rna_pkg::ST_DIV_RUN: begin
        div_quo  <= quo_next;
        div_rem  <= rem_next;
        div_step <= div_step + 1'b1;
        if (div_step == STEP_W'(PSUM_W - 1)) begin
          means[div_sel] <= div_neg ? -quo_next : quo_next;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      neighbor_count <= found_count;
      no_neighbors   <= (found_count == '0);
      if (found_count == '0) begin
        mean_position_x <= '0;
        mean_position_y <= '0;
        mean_velocity_x <= '0;
        mean_velocity_y <= '0;
      end else begin
        mean_position_x <= means[rna_pkg::SEL_POS_X][POS_W-1:0];
        mean_position_y <= means[rna_pkg::SEL_POS_Y][POS_W-1:0];
        mean_velocity_x <= means[rna_pkg::SEL_VEL_X][VEL_W-1:0];
        mean_velocity_y <= means[rna_pkg::SEL_VEL_Y][VEL_W-1:0];
      end
    end
  end

  // Checks
  a_flag_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (no_neighbors == (neighbor_count == '0)))
    else $error("no_neighbors disagrees with neighbor_count");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_neighbors) |-> (mean_position_x == '0 && mean_position_y == '0 &&
                                      mean_velocity_x == '0 && mean_velocity_y == '0))
    else $error("non-zero mean with no neighbours");

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    p3_v |-> (state == rna_pkg::ST_WALK || state == rna_pkg::ST_DRAIN))
    else $error("walk pipeline active outside the walk");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(found_count) <= 32'(walk_len))
    else $error("neighbour count exceeds walk length");

endmodule

/* verif/tb_radius_neighbor_average.sv */
// Testbench for radius_neighbor_average: directed table then randomised phases against a predictor.
`timescale 1ns / 1ps
module tb_radius_neighbor_average;

  localparam int IDX_W = rna_pkg::IDX_W;
  localparam int POS_W = rna_pkg::POS_W;
  localparam int VEL_W = rna_pkg::VEL_W;
  localparam int CNT_W = rna_pkg::CNT_W;
  localparam int RAD_W = rna_pkg::RAD_W;
  localparam int AIU_W = rna_pkg::AIU_W;

  localparam int AGENT_SLOTS   = 64;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 820;
  localparam int HOLD_PERIOD   = 8192;
  localparam int HOLD_START    = 7600;
  localparam int MAX_REPORTS   = 10;
  localparam int FAR_HUB_X     = 100000;
  localparam int FAR_HUB_Y     = -100000;
  localparam int FAR_SPREAD    = 2000;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } agent_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [POS_W-1:0] mean_px;
    logic signed [POS_W-1:0] mean_py;
    logic signed [VEL_W-1:0] mean_vx;
    logic signed [VEL_W-1:0] mean_vy;
    logic                    empty;
  } neighbor_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_HEAVY, RX_TOGGLE} stall_pattern_t;

  typedef struct {
    row_kind_t        kind;
    agent_item_t      item;
    logic [RAD_W-1:0] radius;
    logic [AIU_W-1:0] agents;
    bit               pinned;
    neighbor_result_t want;
  } directed_row_t;

  localparam neighbor_result_t NO_NEIGHBOURS = '{count: '0, mean_px: '0, mean_py: '0,
                                                 mean_vx: '0, mean_vy: '0, empty: 1'b1};
  // two neighbours just inside the radius, one exactly on it; negative means truncate toward zero
  localparam neighbor_result_t BOUNDARY_MEANS = '{count: 6'd2, mean_px: -20'sd56,
                                                  mean_py: -20'sd136, mean_vx: 16'sd1,
                                                  mean_vy: 16'sd3, empty: 1'b0};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    operation = rna_pkg::OP_WRITE;
  logic [IDX_W-1:0]        agent_index = '0;
  logic signed [POS_W-1:0] position_x = '0;
  logic signed [POS_W-1:0] position_y = '0;
  logic signed [VEL_W-1:0] velocity_x = '0;
  logic signed [VEL_W-1:0] velocity_y = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CNT_W-1:0]        neighbor_count;
  logic signed [POS_W-1:0] mean_position_x;
  logic signed [POS_W-1:0] mean_position_y;
  logic signed [VEL_W-1:0] mean_velocity_x;
  logic signed [VEL_W-1:0] mean_velocity_y;
  logic                    no_neighbors;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = rna_pkg::CFG_RADIUS;
  logic [RAD_W-1:0]        cfg_data = '0;

  logic                    pin_row = 1'b0;
  neighbor_result_t        pin_result = '0;

  logic signed [POS_W-1:0] slot_px [AGENT_SLOTS];
  logic signed [POS_W-1:0] slot_py [AGENT_SLOTS];
  logic signed [VEL_W-1:0] slot_vx [AGENT_SLOTS];
  logic signed [VEL_W-1:0] slot_vy [AGENT_SLOTS];
  logic [RAD_W-1:0]        radius_cfg;
  logic [AIU_W-1:0]        agents_cfg;
  neighbor_result_t        pending_results [$];
  int unsigned             mismatches = 0;
  int unsigned             idle_cycles = 0;
  int unsigned             burst_left = 0;
  int unsigned             rx_cycle;
  stall_pattern_t          rx_mode;

  radius_neighbor_average dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .agent_index     (agent_index),
    .position_x      (position_x),
    .position_y      (position_y),
    .velocity_x      (velocity_x),
    .velocity_y      (velocity_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .neighbor_count  (neighbor_count),
    .mean_position_x (mean_position_x),
    .mean_position_y (mean_position_y),
    .mean_velocity_x (mean_velocity_x),
    .mean_velocity_y (mean_velocity_y),
    .no_neighbors    (no_neighbors),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic neighbor_result_t average_neighbours(input logic [IDX_W-1:0] centre);
    longint cx, cy, dx, dy, r2, sum_px, sum_py, sum_vx, sum_vy;
    int walk, found, i;
    neighbor_result_t res;
    cx = slot_px[centre];
    cy = slot_py[centre];
    walk = (agents_cfg > AGENT_SLOTS) ? AGENT_SLOTS : int'(agents_cfg);
    r2 = longint'(radius_cfg) * longint'(radius_cfg);
    sum_px = 0;
    sum_py = 0;
    sum_vx = 0;
    sum_vy = 0;
    found = 0;
    for (i = 0; i < walk; i++) begin
      dx = slot_px[i] - cx;
      dy = slot_py[i] - cy;
      if (i != centre && dx * dx + dy * dy < r2 && found < rna_pkg::COUNT_CAP) begin
        sum_px += slot_px[i];
        sum_py += slot_py[i];
        sum_vx += slot_vx[i];
        sum_vy += slot_vy[i];
        found++;
      end
    end
    if (found == 0) begin
      res = NO_NEIGHBOURS;
    end else begin
      res.count   = CNT_W'(found);
      res.mean_px = POS_W'(sum_px / found);
      res.mean_py = POS_W'(sum_py / found);
      res.mean_vx = VEL_W'(sum_vx / found);
      res.mean_vy = VEL_W'(sum_vy / found);
      res.empty   = 1'b0;
    end
    return res;
  endfunction

  function automatic agent_item_t cluster_write(input int idx, input longint hub_x, hub_y,
                                                input int unsigned spread);
    agent_item_t it;
    it.op  = rna_pkg::OP_WRITE;
    it.idx = IDX_W'(idx);
    it.px  = POS_W'(hub_x + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
    it.py  = POS_W'(hub_y + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
    it.vx  = VEL_W'($urandom);
    it.vy  = VEL_W'($urandom);
    return it;
  endfunction

  function automatic directed_row_t cfg_row(input int unsigned radius, agents);
    directed_row_t row;
    row.kind   = ROW_CFG;
    row.item   = '0;
    row.radius = RAD_W'(radius);
    row.agents = AIU_W'(agents);
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic directed_row_t item_row(input logic op, input int idx, px, py, vx, vy,
                                             input bit pinned, input neighbor_result_t want);
    directed_row_t row;
    row.kind   = ROW_ITEM;
    row.item   = '{op: op, idx: IDX_W'(idx), px: POS_W'(px), py: POS_W'(py),
                   vx: VEL_W'(vx), vy: VEL_W'(vy)};
    row.radius = '0;
    row.agents = '0;
    row.pinned = pinned;
    row.want   = want;
    return row;
  endfunction

  function automatic string show_result(input neighbor_result_t r);
    return $sformatf("n=%0d pos=(%0d,%0d) vel=(%0d,%0d) none=%0b", r.count,
                     $signed(r.mean_px), $signed(r.mean_py), $signed(r.mean_vx),
                     $signed(r.mean_vy), r.empty);
  endfunction

  task automatic report_mismatch(input string what, input neighbor_result_t want, got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: expected %s, got %s", $realtime, what, show_result(want),
               show_result(got));
  endtask

  task automatic offer(input agent_item_t it, input bit pinned, input neighbor_result_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    in_valid    <= 1'b1;
    operation   <= it.op;
    agent_index <= it.idx;
    position_x  <= it.px;
    position_y  <= it.py;
    velocity_x  <= it.vx;
    velocity_y  <= it.vy;
    pin_row     <= pinned;
    pin_result  <= want;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [RAD_W-1:0] radius, input logic [AIU_W-1:0] agents);
    cfg_valid <= 1'b1;
    cfg_index <= rna_pkg::CFG_RADIUS;
    cfg_data  <= radius;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= rna_pkg::CFG_AGENTS;
    cfg_data  <= RAD_W'(agents);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result sink: shifting stall patterns plus a long periodic hold-off
  always @(posedge clk) begin
    if (rst) begin
      rx_cycle  <= 0;
      rx_mode   <= RX_FLOW;
      out_stall <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0)
        rx_mode <= stall_pattern_t'($urandom_range(0, 3));
      if (rx_cycle % HOLD_PERIOD >= HOLD_START) begin
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_COIN:  out_stall <= 1'($urandom_range(0, 1));
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    neighbor_result_t got, want;
    if (rst) begin
      radius_cfg  = rna_pkg::RADIUS_RESET;
      agents_cfg  = rna_pkg::AGENTS_RESET;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        if (cfg_index == rna_pkg::CFG_RADIUS)
          radius_cfg = cfg_data;
        else
          agents_cfg = cfg_data[AIU_W-1:0];
      end
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        if (operation == rna_pkg::OP_WRITE) begin
          slot_px[agent_index] = position_x;
          slot_py[agent_index] = position_y;
          slot_vx[agent_index] = velocity_x;
          slot_vy[agent_index] = velocity_y;
        end else begin
          pending_results.push_back(pin_row ? pin_result : average_neighbours(agent_index));
        end
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        got = '{neighbor_count, mean_position_x, mean_position_y, mean_velocity_x,
                mean_velocity_y, no_neighbors};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transaction", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.count !== want.count || got.mean_px !== want.mean_px ||
              got.mean_py !== want.mean_py || got.mean_vx !== want.mean_vx ||
              got.mean_vy !== want.mean_vy || got.empty !== want.empty)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t           script [$];
    agent_item_t             it;
    int unsigned             sent, phase_len, spread, radius, agents, lim, i;
    logic signed [POS_W-1:0] hub_x, hub_y;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every slot is written before the first query can read it
    for (i = 0; i < AGENT_SLOTS; i++)
      offer(cluster_write(i, FAR_HUB_X, FAR_HUB_Y, FAR_SPREAD), 1'b0, '0);

    script.push_back(cfg_row(0, 64));
    script.push_back(item_row(rna_pkg::OP_QUERY, 5, 0, 0, 0, 0, 1'b1, NO_NEIGHBOURS));
    script.push_back(cfg_row(20'hFFFFF, 0));
    script.push_back(item_row(rna_pkg::OP_QUERY, 7, 0, 0, 0, 0, 1'b1, NO_NEIGHBOURS));
    script.push_back(cfg_row(20'hFFFFF, 64));
    script.push_back(item_row(rna_pkg::OP_QUERY, 9, 0, 0, 0, 0, 1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 0, 524287, -524288, 32767, -32768,
                              1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 1, -524288, 524287, -32768, 32767,
                              1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_QUERY, 1, -1, -1, -1, -1, 1'b0, '0));
    script.push_back(cfg_row(20'hFFFFF, 100));
    script.push_back(item_row(rna_pkg::OP_QUERY, 63, 0, 0, 0, 0, 1'b0, '0));
    script.push_back(cfg_row(5000, 4));
    script.push_back(item_row(rna_pkg::OP_QUERY, 40, 0, 0, 0, 0, 1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 0, FAR_HUB_X, FAR_HUB_Y, 12, -12,
                              1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 1, FAR_HUB_X + 16, FAR_HUB_Y - 16, -5, 9,
                              1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 2, 0, 0, 100, 100, 1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 3, 160, 0, 50, -50, 1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 4, 0, -159, 7, -3, 1'b0, '0));
    script.push_back(item_row(rna_pkg::OP_WRITE, 5, -113, -113, -4, 10, 1'b0, '0));
    script.push_back(cfg_row(160, 64));
    script.push_back(item_row(rna_pkg::OP_QUERY, 2, 0, 0, 0, 0, 1'b1, BOUNDARY_MEANS));
    script.push_back(item_row(rna_pkg::OP_QUERY, 3, 0, 0, 0, 0, 1'b1, NO_NEIGHBOURS));

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        settle();
        write_config(script[r].radius, script[r].agents);
      end else begin
        offer(script[r].item, script[r].pinned, script[r].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       spread = 32;
        1:       spread = 400;
        2:       spread = 6000;
        default: spread = 524288;
      endcase
      case ($urandom_range(0, 5))
        0:       radius = 0;
        1:       radius = 20'hFFFFF;
        default: radius = $urandom_range(0, 3 * spread);
      endcase
      if (radius > 20'hFFFFF)
        radius = 20'hFFFFF;
      case ($urandom_range(0, 7))
        0:       agents = 64;
        1:       agents = 1;
        2:       agents = 0;
        3:       agents = 127;
        default: agents = $urandom_range(1, 64);
      endcase
      lim = (agents > AGENT_SLOTS) ? AGENT_SLOTS : agents;
      settle();
      write_config(RAD_W'(radius), AIU_W'(agents));
      hub_x = POS_W'($urandom);
      hub_y = POS_W'($urandom);
      phase_len = $urandom_range(40, 140);
      if (phase_len > RANDOM_ITEMS - sent)
        phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 5) begin
          it = cluster_write(0, hub_x, hub_y, spread);
        end else begin
          it = '{op: rna_pkg::OP_QUERY, idx: '0, px: POS_W'($urandom), py: POS_W'($urandom),
                 vx: VEL_W'($urandom), vy: VEL_W'($urandom)};
        end
        if (lim == 0 || $urandom_range(0, 3) == 0)
          it.idx = IDX_W'($urandom_range(0, AGENT_SLOTS - 1));
        else
          it.idx = IDX_W'($urandom_range(0, lim - 1));
        offer(it, 1'b0, '0);
        sent++;
      end
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* radius_neighbor_average.f */
rtl/rna_pkg.sv
rtl/radius_neighbor_average.sv
verif/tb_radius_neighbor_average.sv
